// ----- design/trf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package trf_pkg;
    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_FIELD  = 2'd1,
        REQ_BYTE   = 2'd2,
        REQ_END    = 2'd3
    } t_req;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_MASK = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_ORDER    = 2'd3;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [12:0] LEN_MAX = 13'h1FFF;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // queued command between front and back
    typedef struct packed {
        t_req        req;
        logic [31:0] seq;
        logic [31:0] ms;
        logic [7:0]  mask;
        logic [7:0]  fbyte;
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'd0};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        crc_update = c;
    endfunction
endpackage
`default_nettype wire

// ----- design/trf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire trf_pkg::t_cmd i_cmd,
    output logic               o_q_valid,
    input  wire logic          i_q_ready,
    output trf_pkg::t_cmd      o_q_cmd
);
    import trf_pkg::*;

    // two-entry queue; zero field bytes are dropped on entry
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop, w_keep;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_keep    = !(i_cmd.req == REQ_BYTE && i_cmd.fbyte == 8'd0);
    assign w_push    = i_valid && o_ready && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ----- design/trf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trf_back #(
    parameter int FIELD_COUNT = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [12:0]   i_max_len,
    input  wire logic          i_q_valid,
    output logic               o_q_ready,
    input  wire trf_pkg::t_cmd i_q_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last,
    output logic [1:0]         o_status
);
    import trf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TAG, S_SEQ_CONV, S_SEQ_OUT, S_COMMA2, S_MS_CONV, S_MS_OUT,
        S_COMMA3, S_MASK_HI, S_MASK_LO, S_TRAILER
    } t_state;

    t_state      r_state;
    logic [15:0] r_crc;
    logic [12:0] r_len;
    logic [3:0]  r_fields;
    logic [1:0]  r_err;
    logic        r_inrec;
    t_cmd        r_cmd;
    logic [31:0] r_val;
    logic [39:0] r_digits;
    logic [3:0]  r_ndig;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic [1:0]  r_ostat;

    logic        w_space;
    logic [31:0] w_quot;
    logic [3:0]  w_rem;
    logic [35:0] w_prod;
    logic [15:0] w_crc_next;
    logic [7:0]  w_body;
    logic        w_emit;
    logic [13:0] w_tot;
    logic [1:0]  w_st;

    assign o_valid  = r_ovalid;
    assign o_byte   = r_obyte;
    assign o_last   = r_olast;
    assign o_status = r_ostat;
    assign w_space  = !r_ovalid || i_ready;
    assign o_q_ready = (r_state == S_IDLE) && w_space;

    // divide by ten: 32x32 reciprocal multiply and shift
    logic [63:0] w_mul;
    assign w_mul  = r_val * 32'hCCCCCCCD;
    assign w_quot = {3'd0, w_mul[63:35]};
    assign w_prod = {4'd0, w_quot} * 36'd10;
    assign w_rem  = 4'(r_val - w_prod[31:0]);

    // byte that goes into the crc this cycle
    always_comb begin
        w_emit = 1'b0;
        w_body = CH_COMMA;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_space) begin
                    if (i_q_cmd.req == REQ_HEADER) begin
                        w_emit = 1'b1;
                        w_body = CH_P;
                    end else if (r_inrec && i_q_cmd.req == REQ_FIELD) begin
                        w_emit = 1'b1;
                    end else if (r_inrec && i_q_cmd.req == REQ_BYTE) begin
                        w_emit = 1'b1;
                        w_body = i_q_cmd.fbyte;
                    end
                end
            end
            S_TAG: begin
                w_emit = w_space;
                w_body = (r_idx == 3'd0) ? CH_M : (r_idx == 3'd1) ? CH_ONE : CH_COMMA;
            end
            S_SEQ_OUT, S_MS_OUT: begin
                // most significant digit sits in the lowest nibble
                w_emit = w_space;
                w_body = CH_ZERO + {4'd0, r_digits[3:0]};
            end
            S_COMMA2, S_COMMA3: w_emit = w_space;
            S_MASK_HI: begin
                w_emit = w_space;
                w_body = hex_digit(r_cmd.mask[7:4]);
            end
            S_MASK_LO: begin
                w_emit = w_space;
                w_body = hex_digit(r_cmd.mask[3:0]);
            end
            default: ;
        endcase
    end

    assign w_crc_next = crc_update((r_state == S_IDLE && i_q_cmd.req == REQ_HEADER)
                                   ? CRC_INIT : r_crc, w_body);
    assign w_tot = {1'b0, r_len} + 14'd6;

    always_comb begin
        if (r_err == ST_BAD_MASK) w_st = ST_BAD_MASK;
        else if (w_tot >= {1'b0, i_max_len}) w_st = ST_OVERFLOW;
        else if (r_err == ST_ORDER || r_fields != 4'(FIELD_COUNT)) w_st = ST_ORDER;
        else w_st = ST_OK;
    end

    // sequencer with registered output byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_crc    <= CRC_INIT;
            r_len    <= 13'd0;
            r_fields <= 4'd0;
            r_err    <= ST_OK;
            r_inrec  <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= 3'd0;
            r_ndig   <= 4'd0;
        end else begin
            if (w_emit || (r_state == S_TRAILER && w_space)) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (w_emit) begin
                r_obyte  <= w_body;
                r_olast  <= 1'b0;
                r_ostat  <= ST_OK;
                r_crc    <= w_crc_next;
                if (r_state == S_IDLE && i_q_cmd.req == REQ_HEADER) r_len <= 13'd1;
                else if (r_len != LEN_MAX) r_len <= r_len + 13'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && w_space) begin
                        case (i_q_cmd.req)
                            REQ_HEADER: begin
                                r_cmd    <= i_q_cmd;
                                r_fields <= 4'd0;
                                r_err    <= (i_q_cmd.mask > 8'h07) ? ST_BAD_MASK : ST_OK;
                                r_inrec  <= 1'b1;
                                r_idx    <= 3'd0;
                                r_state  <= S_TAG;
                            end
                            REQ_FIELD: begin
                                if (r_inrec) begin
                                    if (r_fields != 4'd15) r_fields <= r_fields + 4'd1;
                                    if (r_fields >= 4'(FIELD_COUNT) && r_err == ST_OK)
                                        r_err <= ST_ORDER;
                                end
                            end
                            REQ_BYTE: begin
                                if (r_inrec && r_fields == 4'd0 && r_err == ST_OK)
                                    r_err <= ST_ORDER;
                            end
                            REQ_END: begin
                                if (r_inrec) begin
                                    r_idx   <= 3'd0;
                                    r_state <= S_TRAILER;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TAG: begin
                    if (w_space) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd2) begin
                            r_val    <= r_cmd.seq;
                            r_ndig   <= 4'd0;
                            r_state  <= S_SEQ_CONV;
                        end
                    end
                end
                S_SEQ_CONV, S_MS_CONV: begin
                    // one digit per cycle, least significant first
                    r_digits <= {r_digits[35:0], w_rem};
                    r_ndig   <= r_ndig + 4'd1;
                    r_val    <= w_quot;
                    if (w_quot == 32'd0)
                        r_state <= (r_state == S_SEQ_CONV) ? S_SEQ_OUT : S_MS_OUT;
                end
                S_SEQ_OUT, S_MS_OUT: begin
                    if (w_space) begin
                        r_digits <= {4'd0, r_digits[39:4]};
                        r_ndig   <= r_ndig - 4'd1;
                        if (r_ndig == 4'd1)
                            r_state <= (r_state == S_SEQ_OUT) ? S_COMMA2 : S_COMMA3;
                    end
                end
                S_COMMA2: begin
                    if (w_space) begin
                        r_val   <= r_cmd.ms;
                        r_ndig  <= 4'd0;
                        r_state <= S_MS_CONV;
                    end
                end
                S_COMMA3: if (w_space) r_state <= S_MASK_HI;
                S_MASK_HI: if (w_space) r_state <= S_MASK_LO;
                S_MASK_LO: if (w_space) r_state <= S_IDLE;
                S_TRAILER: begin
                    if (w_space) begin
                        r_olast  <= 1'b0;
                        r_ostat  <= ST_OK;
                        r_idx    <= r_idx + 3'd1;
                        case (r_idx)
                            3'd0: r_obyte <= CH_STAR;
                            3'd1: r_obyte <= hex_digit(r_crc[15:12]);
                            3'd2: r_obyte <= hex_digit(r_crc[11:8]);
                            3'd3: r_obyte <= hex_digit(r_crc[7:4]);
                            3'd4: r_obyte <= hex_digit(r_crc[3:0]);
                            default: begin
                                r_obyte <= CH_NL;
                                r_olast <= 1'b1;
                                r_ostat <= w_st;
                                r_inrec <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/telemetry_record_framer_crc16_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  tdata                                              tuser
// s_axis    in         seq[31:0] ms[63:32] mask[71:64] byte[79:72]        req_type
// m_axis    out        out_byte[7:0]                                      record_status
// cfg       in         max_record_length (i_cfg_we / i_cfg_wdata)         -
// field start and field byte items: one output byte per cycle while the output is not stalled
// header: each decimal number is converted to digits first, then its digits are sent byte by byte
// end item: taken from the queue, then six bytes: a star, four hex crc digits and a newline
// reset is synchronous, active low; it clears the queue, state and capacity to 256
// either side may stall; a two-entry queue and an output register decouple them
module telemetry_record_framer_crc16_top #(
    parameter int FIELD_COUNT = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // sequence_number, source_millis, field_mask, field_byte
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_byte
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser   // record_status
);
    import trf_pkg::*;

    logic [12:0] r_max_len;
    t_cmd        w_in_cmd, w_q_cmd;
    logic        w_q_valid, w_q_ready;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_len <= 13'd256;
        else if (i_cfg_we) r_max_len <= i_cfg_wdata;
    end

    assign w_in_cmd.req   = t_req'(s_axis_tuser);
    assign w_in_cmd.seq   = s_axis_tdata[31:0];
    assign w_in_cmd.ms    = s_axis_tdata[63:32];
    assign w_in_cmd.mask  = s_axis_tdata[71:64];
    assign w_in_cmd.fbyte = s_axis_tdata[79:72];

    trf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in_cmd),
        .o_q_valid(w_q_valid), .i_q_ready(w_q_ready), .o_q_cmd(w_q_cmd)
    );

    trf_back #(.FIELD_COUNT(FIELD_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_len(r_max_len),
        .i_q_valid(w_q_valid), .o_q_ready(w_q_ready), .i_q_cmd(w_q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_byte(m_axis_tdata), .o_last(m_axis_tlast), .o_status(m_axis_tuser)
    );
endmodule
`default_nettype wire

// ----- design/trf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [1:0] m_axis_tuser
);
    // stalled output transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // last byte is the newline
    a_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h0A)
        else $error("last without newline");
    // status only on last
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == 2'd0)
        else $error("status on non-last byte");
    // nothing out right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind telemetry_record_framer_crc16_top trf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
